// ===== rtl/mtwg_pkg.sv =====
// Shared constants, types and word functions of the MT19937 word generator.
package mtwg_pkg;

   localparam int          WORD_WIDTH   = 32;
   localparam int          TWIST_OFFSET = 397;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [31:0] SEED_MULT    = 32'd69069;

   // Request opcodes.
   localparam logic OP_RESEED   = 1'b0;
   localparam logic OP_GENERATE = 1'b1;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Control handed from the seeding sequencer to the cell chain.
   typedef struct packed {
      logic     active;
      word_type word;
   } seed_ctl_type;

   // One twist step: upper bit of the head word, lower bits of its neighbor.
   function automatic word_type twist_word(input word_type head, input word_type nxt,
                                           input word_type far);
      word_type y;
      y = {head[31], nxt[30:0]};
      return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
   endfunction

   // Standard MT19937 output tempering.
   function automatic word_type temper_word(input word_type w_in);
      word_type w;
      w = w_in;
      w = w ^ (w >> 11);
      w = w ^ ((w << 7) & TEMPER_B);
      w = w ^ ((w << 15) & TEMPER_C);
      w = w ^ (w >> 18);
      return w;
   endfunction

endpackage

// ===== rtl/mtwg_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
interface mtwg_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] seed_value;

   modport source (output valid, output opcode, output seed_value, input ready);
   modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mtwg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/mtwg_cell.sv =====
// One word cell of the state chain: takes its neighbor's word on each shift.
module mtwg_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  mtwg_pkg::word_type d_in,
   output mtwg_pkg::word_type q
);
   import mtwg_pkg::*;

   word_type word_ff;
   word_type word_in;

   // Hold the word unless the chain shifts.
   always_comb begin
      word_in = shift_en ? d_in : word_ff;
   end

   // The table reads as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign q = word_ff;

endmodule

// ===== rtl/mtwg_seeder.sv =====
// Seeding sequencer: streams seed * 69069^k into the cell chain, one word a cycle.
module mtwg_seeder #(
   parameter int STATE_WORDS = 624
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mtwg_pkg::word_type     seed,
   output mtwg_pkg::seed_ctl_type ctl
);
   import mtwg_pkg::*;

   localparam int CountWidth = $clog2(STATE_WORDS);

   localparam logic StIdle = 1'b0;
   localparam logic StFill = 1'b1;

   logic                  state_ff;
   logic                  state_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   word_type              word_ff;
   word_type              word_in;
   logic                  last_word;

   assign last_word = (count_ff == CountWidth'(STATE_WORDS - 1));

   // Next state, fill count and next seed word.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      word_in  = word_ff;
      case (state_ff)
         StIdle: begin
            if (start) begin
               state_in = StFill;
               count_in = '0;
               word_in  = seed;
            end
         end
         StFill: begin
            word_in  = 32'(word_ff * SEED_MULT);
            count_in = count_ff + 1'b1;
            if (last_word) begin
               state_in = StIdle;
               count_in = '0;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // The seed word is payload and needs no reset.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign ctl.active = (state_ff == StFill);
   assign ctl.word   = word_ff;

   // A fill always ends after exactly one word per table entry.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StFill) && last_word |=> (state_ff == StIdle))
      else $error("seeder did not stop after the last table word");

   // A start in idle always opens a fill at count zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle) && start |=> (state_ff == StFill) && (count_ff == '0))
      else $error("seeder did not begin a fill on start");

   // The count never passes the last entry.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(STATE_WORDS - 1))
      else $error("seeder count out of range");

endmodule

// ===== rtl/mersenne_twister_word_generator.sv =====
// MT19937 word generator top level: request and response channels around the cell chain.
//
// The 624-word state lives in a chain of word cells that rotates by one cell per
// generated word, so the head cell always holds the word at the current position and
// taps at cells 1 and 397 give the twist operands. In a generate transaction (opcode 1)
// the twisted word enters the tail of the chain and its tempered value is registered as
// the response, so generates run back to back at one per cycle as long as the response
// side takes each word. A reseed transaction (opcode 0) streams the seed and its successive
// products by 69069 into the chain, one word a cycle through a single multiplier, and keeps
// the request side stalled until the whole table is filled; it gives no response. After
// reset the table is all zeros and generates return zero until a reseed.
module mersenne_twister_word_generator #(
   parameter int STATE_WORDS = 624
) (
   input  logic       clock,
   input  logic       reset,
   mtwg_req_if.sink   req_chan,
   mtwg_rsp_if.source rsp_chan
);
   import mtwg_pkg::*;

   word_type     cell_q [STATE_WORDS];
   word_type     tail_word;
   word_type     twisted;
   seed_ctl_type seed_ctl;
   logic         shift_en;
   logic         req_fire;
   logic         gen_fire;
   logic         seed_fire;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   word_type     rsp_word_ff;
   word_type     rsp_word_in;

   // Request handshake: stalled while seeding or while a result is still held.
   assign req_chan.ready = !seed_ctl.active && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign gen_fire       = req_fire && (req_chan.opcode == OP_GENERATE);
   assign seed_fire      = req_fire && (req_chan.opcode == OP_RESEED);

   // Seeding sequencer.
   mtwg_seeder #(
      .STATE_WORDS(STATE_WORDS)
   ) u_seeder (
      .clock (clock),
      .reset (reset),
      .start (seed_fire),
      .seed  (req_chan.seed_value),
      .ctl   (seed_ctl)
   );

   // Twist of the head word; it becomes the new tail word unless the chain is seeding.
   assign twisted   = twist_word(cell_q[0], cell_q[1], cell_q[TWIST_OFFSET]);
   assign tail_word = seed_ctl.active ? seed_ctl.word : twisted;
   assign shift_en  = seed_ctl.active || gen_fire;

   // Chain of word cells, each fed by its upper neighbor.
   for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
      word_type cell_d;
      if (i == STATE_WORDS - 1) begin : g_tail
         assign cell_d = tail_word;
      end else begin : g_body
         assign cell_d = cell_q[i+1];
      end
      mtwg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     (cell_d),
         .q        (cell_q[i])
      );
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (gen_fire) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = temper_word(twisted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.random_word = rsp_word_ff;

   // No request is taken while the chain is being filled.
   assert property (@(posedge clock) disable iff (reset)
      seed_ctl.active |-> !req_chan.ready)
      else $error("request accepted during seeding");

   // Every generate yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      gen_fire |=> rsp_valid_ff)
      else $error("generate produced no response");

   // A reseed starts the fill and produces no response of its own.
   assert property (@(posedge clock) disable iff (reset)
      seed_fire |=> seed_ctl.active && (rsp_valid_ff == $past(rsp_valid_ff && !rsp_chan.ready)))
      else $error("reseed did not start a fill cleanly");

   // A held response word changes only when a new generate is accepted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(rsp_word_ff))
      else $error("held response word changed");

endmodule

// ===== bench/word_stream_checker.sv =====
// Checker for the MT19937 word generator: predicts each tempered word and compares responses.
`timescale 1ns / 1ps

module word_stream_checker (
   input  logic  clock,
   input  logic  reset,
   mtwg_req_if   req_mon,
   mtwg_rsp_if   rsp_mon,
   output int    fail_count,
   output int    words_pending,
   output int    words_checked
);
   import mtwg_pkg::*;

   localparam int TABLE_DEPTH = 624;
   localparam int REPORT_LIMIT = 10;

   // Predicted generator state: the word table and the current position.
   word_type    table_words [TABLE_DEPTH];
   int unsigned cursor;

   // Tempered words still owed by the block, oldest first.
   word_type    owed_words [$];
   word_type    owed_word;

   // Rebuild the table from a seed: each word is the previous one times 69069.
   task automatic fill_table(input word_type seed);
      table_words[0] = seed;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         table_words[k] = table_words[k-1] * SEED_MULT;
      end
      cursor = 0;
   endtask

   // Twist the word at the cursor in place, advance the cursor and return the tempered word.
   function automatic word_type advance_generator();
      int unsigned head;
      int unsigned succ;
      int unsigned far_idx;
      word_type    mixed;
      word_type    fresh;
      head    = (cursor >= TABLE_DEPTH) ? 0 : cursor;
      succ    = (head + 1) % TABLE_DEPTH;
      far_idx = (head + TWIST_OFFSET) % TABLE_DEPTH;
      mixed   = {table_words[head][31], table_words[succ][30:0]};
      fresh   = table_words[far_idx] ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MATRIX : word_type'(0));
      table_words[head] = fresh;
      cursor  = succ;
      fresh   = fresh ^ (fresh >> 11);
      fresh   = fresh ^ ((fresh << 7) & TEMPER_B);
      fresh   = fresh ^ ((fresh << 15) & TEMPER_C);
      fresh   = fresh ^ (fresh >> 18);
      return fresh;
   endfunction

   // Count a failure; only the first few are described in full.
   task automatic note_failure(input string what, input word_type want, input word_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
      end
   endtask

   initial begin
      fail_count    = 0;
      words_pending = 0;
      words_checked = 0;
   end

   // Watch both channels; responses are checked before the new request is predicted.
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            table_words[k] = '0;
         end
         cursor = 0;
         owed_words.delete();
         words_pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_words.size() == 0) begin
               note_failure("response with no word owed", '0, rsp_mon.random_word);
            end else begin
               owed_word = owed_words.pop_front();
               words_checked++;
               if (rsp_mon.random_word !== owed_word) begin
                  note_failure("random_word mismatch", owed_word, rsp_mon.random_word);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.opcode == OP_RESEED) begin
               fill_table(req_mon.seed_value);
            end else begin
               owed_words.push_back(advance_generator());
            end
         end
         words_pending <= owed_words.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the MT19937 word generator bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import mtwg_pkg::*;

   localparam int RANDOM_ITEMS  = 640;
   localparam int WRAP_RUN      = 630;
   localparam int SETTLE_CYCLES = 700;
   localparam int IDLE_LIMIT    = 5000;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_EVERY_FOURTH,
      DRAIN_LONG_HOLD
   } drain_mode_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;

   // Request driver state.
   logic           feed_valid  = 1'b0;
   logic           feed_opcode = OP_GENERATE;
   word_type       feed_seed   = '0;
   int             burst_left  = 0;
   int             reseeds_sent = 0;
   int             generates_sent = 0;

   // Response receiver state.
   logic           drain_ready = 1'b0;
   drain_mode_type drain_mode  = DRAIN_FREE;
   int             mode_left   = 0;
   logic [3:0]     tick        = '0;

   int             idle_cycles = 0;
   int             fail_count;
   int             words_pending;
   int             words_checked;

   mtwg_req_if req_chan ();
   mtwg_rsp_if rsp_chan ();

   assign req_chan.valid      = feed_valid;
   assign req_chan.opcode     = feed_opcode;
   assign req_chan.seed_value = feed_seed;
   assign rsp_chan.ready      = drain_ready;

   mersenne_twister_word_generator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   word_stream_checker check_words (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stalls: switch at random between four ready patterns.
   always @(posedge clock) begin
      if (reset) begin
         drain_ready <= 1'b0;
         drain_mode  <= DRAIN_FREE;
         mode_left   <= 0;
         tick        <= '0;
      end else begin
         tick <= tick + 1'b1;
         if (mode_left == 0) begin
            drain_mode <= drain_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (drain_mode)
            DRAIN_FREE:         drain_ready <= 1'b1;
            DRAIN_COIN:         drain_ready <= 1'($urandom_range(0, 1));
            DRAIN_EVERY_FOURTH: drain_ready <= (tick[1:0] == 2'd0);
            default:            drain_ready <= (tick >= 4'd12);
         endcase
      end
   end

   // Watchdog: too long without any transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((feed_valid && req_chan.ready) || (rsp_chan.valid && drain_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request, wait for its transaction, then keep the burst going or pause.
   task automatic issue(input logic op, input word_type seed);
      feed_valid  <= 1'b1;
      feed_opcode <= op;
      feed_seed   <= seed;
      do @(posedge clock); while (!req_chan.ready);
      if (op == OP_RESEED) begin
         reseeds_sent++;
      end else begin
         generates_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         feed_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // Now and then a long stretch without gaps.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(0, 20);
      end
   endtask

   initial begin
      int       random_items;
      int       run_index;
      int       run_len;
      word_type seed;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: generates on the all-zero table, then reseeds at the seed extremes.
      repeat (3) issue(OP_GENERATE, $urandom);
      issue(OP_RESEED, 32'h0000_0000);
      repeat (2) issue(OP_GENERATE, $urandom);
      issue(OP_RESEED, 32'hffff_ffff);
      repeat (3) issue(OP_GENERATE, $urandom);
      issue(OP_RESEED, 32'h0000_0001);
      repeat (2) issue(OP_GENERATE, $urandom);
      issue(OP_RESEED, 32'h8000_0000);
      repeat (2) issue(OP_GENERATE, $urandom);
      issue(OP_RESEED, 32'd5489);
      issue(OP_GENERATE, 32'hffff_ffff);
      // Back-to-back reseeds: only the second one may count.
      issue(OP_RESEED, 32'h7fff_ffff);
      issue(OP_RESEED, 32'haaaa_aaaa);
      repeat (2) issue(OP_GENERATE, 32'h5555_5555);

      // Random: a reseed followed by a run of generates; the first run wraps the position.
      random_items = 0;
      run_index    = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       seed = '0;
            1:       seed = '1;
            2:       seed = word_type'(1) << $urandom_range(0, 31);
            default: seed = $urandom;
         endcase
         run_len = (run_index == 0) ? WRAP_RUN : $urandom_range(0, 40);
         issue(OP_RESEED, seed);
         repeat (run_len) issue(OP_GENERATE, $urandom);
         random_items += run_len + 1;
         run_index++;
      end
      feed_valid <= 1'b0;

      // Drain the owed words, then give a possible trailing reseed time to finish.
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Issued %0d reseeds and %0d generates, %0d words checked.",
               reseeds_sent, generates_sent, words_checked);
      $display("Seeds included zero, all ones and single bits; one run wrapped the table.");
      if (fail_count == 0 && words_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures, %0d words still owed", fail_count, words_pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
